// ===== design/aes_pkg.sv =====
// Shared types, constants and byte functions for the AES encryption block.
package aes_pkg;

  localparam int RkDepth = 60;
  localparam int RkAw    = $clog2(RkDepth);

  localparam logic [2:0] CFG_KEY0 = 3'd0;
  localparam logic [2:0] CFG_KEY1 = 3'd1;
  localparam logic [2:0] CFG_KEY2 = 3'd2;
  localparam logic [2:0] CFG_KEY3 = 3'd3;
  localparam logic [2:0] CFG_KSIZE = 3'd4;

  localparam logic [1:0] KSIZE_128 = 2'd0;
  localparam logic [1:0] KSIZE_192 = 2'd1;

  localparam logic [7:0] RCON_INIT = 8'h01;

  typedef logic [31:0] word_t;

  // Round-key write request from the expansion unit.
  typedef struct packed {
    logic              we;
    logic [RkAw-1:0]   addr;
    word_t             data;
  } rk_wr_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
  endfunction

  function automatic word_t sub_word(input word_t x);
    return {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
  endfunction

endpackage

// ===== design/aes_key_exp.sv =====
// Key expansion unit: one schedule word per cycle into the round-key store.
module aes_key_exp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic [255:0]             key,
  input  logic [3:0]               nk,
  input  logic [aes_pkg::RkAw-1:0] total,
  output logic                     done,
  output aes_pkg::rk_wr_t          wr
);

  logic                     busy_r;
  logic [aes_pkg::RkAw-1:0] idx_r;
  logic [3:0]               mod_r;
  logic [7:0]               rc_r;
  // last eight words; win_r[0] is w[i-1]
  aes_pkg::word_t           win_r [8];
  aes_pkg::word_t           t;
  aes_pkg::word_t           w;
  aes_pkg::word_t           back;
  logic [2:0]               kidx;

  assign kidx = idx_r[2:0];
  assign back = win_r[3'(nk - 4'd1)];

  always_comb begin
    t = win_r[0];
    if (mod_r == 4'd0) begin
      t = aes_pkg::sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rc_r, 24'd0};
    end else if (nk == 4'd8 && mod_r == 4'd4) begin
      t = aes_pkg::sub_word(win_r[0]);
    end
    if (idx_r < {2'b0, nk}) begin
      w = key[255 - 32*kidx -: 32];
    end else begin
      w = back ^ t;
    end
  end

  assign wr.we   = busy_r;
  assign wr.addr = idx_r;
  assign wr.data = w;
  assign done    = busy_r && (idx_r == total - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (go) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
    if (go) begin
      idx_r <= '0;
      mod_r <= '0;
      rc_r  <= aes_pkg::RCON_INIT;
    end else if (busy_r) begin
      idx_r <= idx_r + 1'b1;
      mod_r <= (mod_r == nk - 4'd1) ? 4'd0 : mod_r + 4'd1;
      if (mod_r == 4'd0 && idx_r >= {2'b0, nk}) begin
        rc_r <= aes_pkg::xtime(rc_r);
      end
      win_r[0] <= w;
      for (int k = 1; k < 8; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

endmodule

// ===== design/aes_round.sv =====
// Shared round unit: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes_round (
  input  logic [127:0] state,
  input  logic [127:0] rkey,
  input  logic         last,
  output logic [127:0] result
);

  logic [7:0] sb [16];
  logic [7:0] sr [16];
  logic [127:0] mixed;
  logic [127:0] shifted;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = aes_pkg::sbox(state[127 - 8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[4*c + r] = sb[4*((c + r) % 4) + r];
      end
    end
    for (int i = 0; i < 16; i++) begin
      shifted[127 - 8*i -: 8] = sr[i];
    end
    for (int c = 0; c < 4; c++) begin
      mixed[127 - 32*c -: 8] = aes_pkg::xtime(sr[4*c]) ^ aes_pkg::xtime(sr[4*c+1])
                               ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
      mixed[119 - 32*c -: 8] = sr[4*c] ^ aes_pkg::xtime(sr[4*c+1])
                               ^ aes_pkg::xtime(sr[4*c+2]) ^ sr[4*c+2] ^ sr[4*c+3];
      mixed[111 - 32*c -: 8] = sr[4*c] ^ sr[4*c+1] ^ aes_pkg::xtime(sr[4*c+2])
                               ^ aes_pkg::xtime(sr[4*c+3]) ^ sr[4*c+3];
      mixed[103 - 32*c -: 8] = aes_pkg::xtime(sr[4*c]) ^ sr[4*c] ^ sr[4*c+1]
                               ^ sr[4*c+2] ^ aes_pkg::xtime(sr[4*c+3]);
    end
    result = (last ? shifted : mixed) ^ rkey;
  end

endmodule

// ===== design/aes_block_encrypt_top.sv =====
// Top level of the AES encryption block: registers, round-key store, sequencer.
//
//  channel | ports                                   | handshake
//  in      | in_block_upper, in_block_lower          | start && !busy
//  out     | out_cipher_upper, out_cipher_lower      | out_valid, one cycle
//  cfg     | cfg_index, cfg_data                     | cfg_valid && cfg_ready
//
// A result is out after its block is taken: one key-row read, one round a cycle on
// the shared round unit, then the output cycle. No new block is taken until the
// sequencer is back in idle, so blocks do not overlap.
// The first block after reset or a key or key-size write first runs key expansion,
// 4*(Nr+1) words (44, 52 or 60), one word a cycle.
// Reset clears control and key registers only. The result is shown for one cycle, no stall.
module aes_block_encrypt_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [63:0]  in_block_upper,
  input  logic [63:0]  in_block_lower,
  output logic         out_valid,
  output logic [63:0]  out_cipher_upper,
  output logic [63:0]  out_cipher_lower,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXP  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]   state_r, state_nxt;
  logic [63:0]  key_r [4];
  logic [1:0]   ksize_r;
  logic         keys_ready_r;
  logic [127:0] blk_r;
  logic [127:0] st_r;
  logic [3:0]   round_r;
  logic [3:0]   nr;
  logic [3:0]   nk;
  logic [aes_pkg::RkAw-1:0] total;
  logic         exp_go;
  logic         exp_done;
  aes_pkg::rk_wr_t rk_wr;
  logic [127:0] rkey_r;
  logic [127:0] rnd_out;
  logic [3:0]   rd_round;
  logic         cfg_hit;

  // round-key store, one row of four words per round
  logic [127:0] rk_mem [aes_pkg::RkDepth/4];

  assign nr    = (ksize_r == aes_pkg::KSIZE_128) ? 4'd10 :
                 (ksize_r == aes_pkg::KSIZE_192) ? 4'd12 : 4'd14;
  assign nk    = nr - 4'd6;
  assign total = aes_pkg::RkAw'({nr, 2'b00} + 6'd4);

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready;
  assign exp_go    = (state_r == ST_IDLE) && start && !keys_ready_r;

  aes_key_exp u_kexp (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (exp_go),
    .key   ({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .nk    (nk),
    .total (total),
    .done  (exp_done),
    .wr    (rk_wr)
  );

  aes_round u_round (
    .state  (st_r),
    .rkey   (rkey_r),
    .last   (round_r == nr),
    .result (rnd_out)
  );

  // read the key row needed by the next cycle's round
  always_comb begin
    rd_round = 4'd0;
    if (state_r == ST_RD) begin
      rd_round = 4'd1;
    end else if (state_r == ST_RUN && round_r != nr) begin
      rd_round = round_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rk_wr.we) begin
      rk_mem[rk_wr.addr[aes_pkg::RkAw-1:2]][127 - 32*rk_wr.addr[1:0] -: 32] <= rk_wr.data;
    end
    rkey_r <= rk_mem[rd_round];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = keys_ready_r ? ST_RD : ST_EXP;
      ST_EXP:  if (exp_done) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_RUN;
      ST_RUN:  if (round_r == nr) state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      keys_ready_r <= 1'b0;
      ksize_r      <= '0;
      for (int k = 0; k < 4; k++) begin
        key_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (exp_done) begin
        keys_ready_r <= 1'b1;
      end
      if (cfg_hit) begin
        unique case (cfg_index)
          aes_pkg::CFG_KEY0:  begin key_r[0] <= cfg_data; keys_ready_r <= 1'b0; end
          aes_pkg::CFG_KEY1:  begin key_r[1] <= cfg_data; keys_ready_r <= 1'b0; end
          aes_pkg::CFG_KEY2:  begin key_r[2] <= cfg_data; keys_ready_r <= 1'b0; end
          aes_pkg::CFG_KEY3:  begin key_r[3] <= cfg_data; keys_ready_r <= 1'b0; end
          aes_pkg::CFG_KSIZE: begin ksize_r <= cfg_data[1:0]; keys_ready_r <= 1'b0; end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      blk_r <= {in_block_upper, in_block_lower};
    end
    if (state_r == ST_RD) begin
      // initial AddRoundKey with row 0
      st_r    <= blk_r ^ rkey_r;
      round_r <= 4'd1;
    end else if (state_r == ST_RUN) begin
      st_r    <= rnd_out;
      round_r <= round_r + 4'd1;
    end
  end

  assign out_valid        = (state_r == ST_OUT);
  assign out_cipher_upper = st_r[127:64];
  assign out_cipher_lower = st_r[63:0];

  a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
  a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result shown twice");
  a_exp_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> keys_ready_r) else $error("round keys not ready");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (round_r <= nr && round_r != 4'd0)) else $error("round out of range");

endmodule
